// ===== hdl/acs_pkg.sv =====
`default_nettype none
package acs_pkg;

  // Machine word width; addresses inside instructions use the low WORD_BITS-3 bits.
  localparam int unsigned WORD_BITS   = 8;
  localparam int unsigned OPC_BITS    = 3;
  localparam int unsigned IADDR_BITS  = WORD_BITS - OPC_BITS;
  localparam int unsigned MEM_DEPTH   = 32;
  localparam int unsigned MADDR_BITS  = $clog2(MEM_DEPTH);
  localparam int unsigned BYTE_BITS   = 8;

  localparam logic [MADDR_BITS-1:0] IN_ADDR_RESET  = MADDR_BITS'(30);
  localparam logic [MADDR_BITS-1:0] OUT_ADDR_RESET = MADDR_BITS'(31);
  localparam logic [WORD_BITS-1:0]  NEWLINE_WORD   = WORD_BITS'(10);

  // Stream word widths, padded to whole bytes.
  localparam int unsigned IN_FIELD_BITS  = MADDR_BITS + 2 * BYTE_BITS;
  localparam int unsigned IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_FIELD_BITS = 2 + 4 * BYTE_BITS - BYTE_BITS;
  localparam int unsigned OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [MEM_DEPTH-1:0][WORD_BITS-1:0] mem_t;

  typedef enum logic [OPC_BITS-1:0] {
    OPC_LOAD  = 3'd0,
    OPC_STORE = 3'd1,
    OPC_ADD   = 3'd2,
    OPC_SUB   = 3'd3,
    OPC_JUMP  = 3'd4,
    OPC_JNEG  = 3'd5,
    OPC_NOP6  = 3'd6,
    OPC_NOP7  = 3'd7
  } opcode_e;

  typedef enum logic {
    OPER_LOAD = 1'b0,
    OPER_STEP = 1'b1
  } oper_e;

  typedef enum logic {
    CFG_IN_ADDR  = 1'b0,
    CFG_OUT_ADDR = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    oper_e                 operation;
    logic [MADDR_BITS-1:0] load_address;
    logic [BYTE_BITS-1:0]  load_data;
    logic [BYTE_BITS-1:0]  in_byte;
  } item_t;

  typedef struct packed {
    logic                 out_valid;
    logic [BYTE_BITS-1:0] out_byte;
    logic                 input_taken;
    logic [BYTE_BITS-1:0] acc_value;
    logic [BYTE_BITS-1:0] ip_value;
  } result_t;

  typedef struct packed {
    logic [MADDR_BITS-1:0] in_addr;
    logic [MADDR_BITS-1:0] out_addr;
  } mbox_cfg_t;

endpackage
`default_nettype wire

// ===== hdl/acs_mem.sv =====
`default_nettype none
// 32-word register file of the machine; reset loads the input mailbox with a newline.
module acs_mem (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         we_i,
  input  wire acs_pkg::mem_t mem_d_i,
  output acs_pkg::mem_t     mem_q_o
);
  import acs_pkg::*;

  mem_t mem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MEM_DEPTH; i++) begin
        mem_q[i] <= (MADDR_BITS'(i) == IN_ADDR_RESET) ? NEWLINE_WORD : '0;
      end
    end else if (we_i) begin
      mem_q <= mem_d_i;
    end
  end

  assign mem_q_o = mem_q;

endmodule
`default_nettype wire

// ===== hdl/acs_exec.sv =====
`default_nettype none
// One machine cycle (or one load) as combinational next-state logic.
module acs_exec (
  input  wire acs_pkg::item_t     item_i,
  input  wire acs_pkg::mbox_cfg_t cfg_i,
  input  wire acs_pkg::mem_t      mem_i,
  input  wire acs_pkg::word_t     acc_i,
  input  wire acs_pkg::word_t     ip_i,
  output acs_pkg::mem_t           mem_o,
  output acs_pkg::word_t          acc_o,
  output acs_pkg::word_t          ip_o,
  output acs_pkg::result_t        res_o
);
  import acs_pkg::*;

  mem_t                  m_fill, m_out, m_exec;
  word_t                 out_word, ir, operand, acc_n, ip_n;
  logic                  taken, emit;
  logic [MADDR_BITS-1:0] fetch_addr, opnd_addr;
  opcode_e               opc;

  always_comb begin
    // input mailbox refill
    m_fill = mem_i;
    taken  = (mem_i[cfg_i.in_addr] == '0);
    if (taken) begin
      m_fill[cfg_i.in_addr] = item_i.in_byte[WORD_BITS-1:0];
    end

    // output mailbox drain, sees a byte just filled at the same address
    m_out    = m_fill;
    out_word = m_fill[cfg_i.out_addr];
    emit     = (out_word != '0);
    if (emit) begin
      m_out[cfg_i.out_addr] = '0;
    end

    // fetch and execute
    fetch_addr = MADDR_BITS'(ip_i[IADDR_BITS-1:0]);
    ir         = m_out[fetch_addr];
    opnd_addr  = MADDR_BITS'(ir[IADDR_BITS-1:0]);
    operand    = m_out[opnd_addr];
    opc        = opcode_e'(ir[WORD_BITS-1 -: OPC_BITS]);
    ip_n       = ip_i + WORD_BITS'(1);
    acc_n      = acc_i;
    m_exec     = m_out;
    case (opc)
      OPC_LOAD:  acc_n = operand;
      OPC_STORE: m_exec[opnd_addr] = acc_i;
      OPC_ADD:   acc_n = acc_i + operand;
      OPC_SUB:   acc_n = acc_i - operand;
      OPC_JUMP:  ip_n = ir;
      OPC_JNEG:  if (acc_i[WORD_BITS-1]) ip_n = ir;
      default:   ;
    endcase

    if (item_i.operation == OPER_LOAD) begin
      mem_o = mem_i;
      mem_o[item_i.load_address] = item_i.load_data[WORD_BITS-1:0];
      acc_o = acc_i;
      ip_o  = ip_i;
      res_o.out_valid   = 1'b0;
      res_o.out_byte    = '0;
      res_o.input_taken = 1'b0;
    end else begin
      mem_o = m_exec;
      acc_o = acc_n;
      ip_o  = ip_n;
      res_o.out_valid   = emit;
      res_o.out_byte    = emit ? BYTE_BITS'(out_word) : '0;
      res_o.input_taken = taken;
    end
    res_o.acc_value = BYTE_BITS'(acc_o);
    res_o.ip_value  = BYTE_BITS'(ip_o);
  end

endmodule
`default_nettype wire

// ===== hdl/accumulator_cpu_step_core.sv =====
// Accumulator machine core, stepped one machine cycle per step word.
// Slave stream: tuser carries the operation (0 = load one memory word,
// 1 = run one machine cycle); tdata carries load_address, load_data and
// in_byte. Every accepted word yields exactly one master word holding
// out_valid, out_byte, input_taken, the accumulator and the instruction
// pointer after that word.
// Config channel: cfg_index_i 0 moves the input mailbox, 1 the output
// mailbox; always ready, and only to be written while the core is idle.
// Path: an accepted word waits in the input register and is executed into
// the result register once that register is free or draining.
// Throughput: one word per clock while results are taken; the input
// register and the result register let a new word come in while a
// result waits to be taken. The whole machine cycle (mailboxes, fetch,
// execute) is one pass of logic between the two registers.
// Reset: memory clears except the input mailbox (address 30) which holds
// a newline, accumulator and pointer clear, both stream registers empty.
// Stall: with the result register full and not taken, a word in the input
// register is held there and s_axis_tready_o drops.
`default_nettype none
module accumulator_cpu_step_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // slave stream
  input  wire logic                                 s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  // [4:0] load_address, [12:5] load_data, [20:13] in_byte
  input  wire logic [acs_pkg::IN_DATA_BITS-1:0]     s_axis_tdata_i,
  // [0] operation
  input  wire logic                                 s_axis_tuser_i,
  // master stream
  output logic                                      m_axis_tvalid_o,
  input  wire logic                                 m_axis_tready_i,
  // [0] out_valid, [8:1] out_byte, [9] input_taken, [17:10] acc_value,
  // [25:18] ip_value
  output logic [acs_pkg::OUT_DATA_BITS-1:0]         m_axis_tdata_o,
  // config write channel
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic                                 cfg_index_i,
  input  wire logic [acs_pkg::MADDR_BITS-1:0]       cfg_data_i
);
  import acs_pkg::*;

  logic      in_vld_q, out_vld_q, advance, s_fire;
  item_t     item_q, item_in;
  result_t   res_q, res_d;
  mbox_cfg_t cfg_q;
  word_t     acc_q, acc_d, ip_q, ip_d;
  mem_t      mem_q, mem_d;

  // unpack the slave word
  assign item_in.operation    = oper_e'(s_axis_tuser_i);
  assign item_in.load_address = s_axis_tdata_i[MADDR_BITS-1:0];
  assign item_in.load_data    = s_axis_tdata_i[MADDR_BITS +: BYTE_BITS];
  assign item_in.in_byte      = s_axis_tdata_i[MADDR_BITS+BYTE_BITS +: BYTE_BITS];

  // execute when a word waits and the result register is free or draining
  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      item_q <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  // mailbox addresses
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_addr  <= IN_ADDR_RESET;
      cfg_q.out_addr <= OUT_ADDR_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_IN_ADDR:  cfg_q.in_addr  <= cfg_data_i;
        CFG_OUT_ADDR: cfg_q.out_addr <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // machine registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      ip_q  <= '0;
    end else if (advance) begin
      acc_q <= acc_d;
      ip_q  <= ip_d;
    end
  end

  acs_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (advance),
    .mem_d_i (mem_d),
    .mem_q_o (mem_q)
  );

  acs_exec u_exec (
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .mem_i  (mem_q),
    .acc_i  (acc_q),
    .ip_i   (ip_q),
    .mem_o  (mem_d),
    .acc_o  (acc_d),
    .ip_o   (ip_d),
    .res_o  (res_d)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_DATA_BITS'({res_q.ip_value, res_q.acc_value,
                                           res_q.input_taken, res_q.out_byte,
                                           res_q.out_valid});

endmodule
`default_nettype wire

// ===== hdl/acs_checker.sv =====
`default_nettype none
module acs_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             m_axis_tvalid_o,
  input wire logic                             m_axis_tready_i,
  input wire logic [acs_pkg::OUT_DATA_BITS-1:0] m_axis_tdata_o
);
  import acs_pkg::*;

  // a stalled result word stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result word dropped while stalled");

  // an emitted character is never zero
  a_emit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |-> m_axis_tdata_o[BYTE_BITS:1] != '0)
    else $error("emitted character is zero");

  // no emission means a zero character field
  a_quiet_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[BYTE_BITS:1] == '0)
    else $error("character field set without emission");

  // a stalled result word keeps its whole data, pointer included
  a_ip_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

endmodule

bind accumulator_cpu_step_core acs_checker u_acs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire
